// ===== rtl/core/circular_mean_angle_assert.svh =====
// ----------------------------------------------------------------------------
// circular_mean_angle assertion macros
// Shared property wrappers for the circular mean block.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_MEAN_ANGLE_ASSERT_SVH
`define CIRCULAR_MEAN_ANGLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CMA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths, types and the arctangent table of the circular mean block.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

    localparam int CORDIC_STEPS = 16;           // 8 .. 24
    localparam int ROM_LEN      = 24;
    localparam int ROM_IDX_W    = 5;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int ANGLE_W = 16;
    localparam int REM_W   = 14;
    localparam int SUM_W   = 28;
    localparam int XY_W    = 48;                // holds sum * 2^16 plus CORDIC growth
    localparam int Z_W     = 34;                // angle in 2^-32 turn, up to ~0.78 turn
    localparam int Q15_W   = 16;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(652032874);
    localparam logic signed [Z_W-1:0]  HALF_TURN       = Z_W'(64'sd2147483648);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_ACC,
        ST_VLOAD,
        ST_VEC,
        ST_OUT
    } t_cma_state;

    // Sequencer to CORDIC unit
    typedef struct packed {
        logic              load;
        logic              vector;
        logic              step;
        logic [STEP_W-1:0] idx;
    } t_cordic_ctl;

    // Sequencer to accumulator
    typedef struct packed {
        logic       add;
        logic       clear;
        logic [1:0] quad;
    } t_acc_ctl;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] atan_rom(input logic [ROM_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cma_cordic.sv =====
// ----------------------------------------------------------------------------
// cma_cordic
// Shared CORDIC stage: one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_cordic (
    input  wire                                   i_clk,
    input  wire cma_pkg::t_cordic_ctl             i_ctl,
    input  wire [cma_pkg::REM_W-1:0]              i_angle_rem,
    input  wire signed [cma_pkg::SUM_W-1:0]       i_cos_sum,
    input  wire signed [cma_pkg::SUM_W-1:0]       i_sin_sum,
    output logic signed [cma_pkg::XY_W-1:0]       o_x,
    output logic signed [cma_pkg::XY_W-1:0]       o_y,
    output logic signed [cma_pkg::Z_W-1:0]        o_z
);
    import cma_pkg::*;

    logic signed [XY_W-1:0] r_x, n_x;
    logic signed [XY_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;

    logic signed [XY_W-1:0] dx, dy, cx, cy;
    logic signed [Z_W-1:0]  da;
    logic                   dir;

    always_comb begin
        dx  = r_y >>> i_ctl.idx;
        dy  = r_x >>> i_ctl.idx;
        da  = atan_rom(ROM_IDX_W'(i_ctl.idx));
        // rotation drives z to zero, vectoring drives y to zero
        dir = i_ctl.vector ? (r_y <= 0) : (r_z >= 0);
        cx  = XY_W'(i_cos_sum) <<< 16;
        cy  = XY_W'(i_sin_sum) <<< 16;

        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_ctl.load) begin
            if (i_ctl.vector) begin
                if (cx < 0) begin
                    n_x = -cx;
                    n_y = -cy;
                    n_z = HALF_TURN;
                end else begin
                    n_x = cx;
                    n_y = cy;
                    n_z = '0;
                end
            end else begin
                n_x = CORDIC_GAIN_Q30;
                n_y = '0;
                n_z = Z_W'(i_angle_rem) <<< 16;
            end
        end else if (i_ctl.step) begin
            if (dir) begin
                n_x = r_x - dx;
                n_y = r_y + dy;
                n_z = r_z - da;
            end else begin
                n_x = r_x + dx;
                n_y = r_y - dy;
                n_z = r_z + da;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

// ===== rtl/core/cma_accum.sv =====
// ----------------------------------------------------------------------------
// cma_accum
// Q1.15 rounding, quadrant fold and saturating cosine and sine sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_accum (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire cma_pkg::t_acc_ctl                i_ctl,
    input  wire signed [cma_pkg::XY_W-1:0]        i_x,
    input  wire signed [cma_pkg::XY_W-1:0]        i_y,
    output logic signed [cma_pkg::SUM_W-1:0]      o_cos_sum,
    output logic signed [cma_pkg::SUM_W-1:0]      o_sin_sum,
    output logic                                  o_sums_zero
);
    import cma_pkg::*;

    localparam logic signed [XY_W-1:0]    RND    = XY_W'(16384);
    localparam logic signed [Q15_W:0]     Q_MAX  = (Q15_W+1)'(32767);
    localparam logic signed [Q15_W:0]     Q_MIN  = -(Q15_W+1)'(32768);
    localparam logic signed [XY_W-1:0]    QW_MAX = XY_W'(32767);
    localparam logic signed [XY_W-1:0]    QW_MIN = -XY_W'(32768);
    localparam logic signed [SUM_W:0]     S_MAX  = (SUM_W+1)'(134217727);
    localparam logic signed [SUM_W:0]     S_MIN  = -(SUM_W+1)'(134217728);

    logic signed [SUM_W-1:0] r_cos_sum, n_cos_sum;
    logic signed [SUM_W-1:0] r_sin_sum, n_sin_sum;

    logic signed [XY_W-1:0]  xr, yr;
    logic signed [Q15_W:0]   cr, sr, c17, s17;
    logic signed [Q15_W-1:0] c16, s16;
    logic signed [SUM_W:0]   cs, ss;

    always_comb begin
        xr = (i_x + RND) >>> 15;
        yr = (i_y + RND) >>> 15;
        cr = (xr > QW_MAX) ? Q_MAX : (xr < QW_MIN) ? Q_MIN : (Q15_W+1)'(xr);
        sr = (yr > QW_MAX) ? Q_MAX : (yr < QW_MIN) ? Q_MIN : (Q15_W+1)'(yr);

        // fold the quadrant back in
        case (i_ctl.quad)
            2'd0:    begin c17 = cr;  s17 = sr;  end
            2'd1:    begin c17 = -sr; s17 = cr;  end
            2'd2:    begin c17 = -cr; s17 = -sr; end
            default: begin c17 = sr;  s17 = -cr; end
        endcase
        c16 = (c17 > Q_MAX) ? Q15_W'(Q_MAX) : Q15_W'(c17);
        s16 = (s17 > Q_MAX) ? Q15_W'(Q_MAX) : Q15_W'(s17);

        cs = (SUM_W+1)'(r_cos_sum) + (SUM_W+1)'(c16);
        ss = (SUM_W+1)'(r_sin_sum) + (SUM_W+1)'(s16);

        n_cos_sum = r_cos_sum;
        n_sin_sum = r_sin_sum;
        if (i_ctl.clear) begin
            n_cos_sum = '0;
            n_sin_sum = '0;
        end else if (i_ctl.add) begin
            n_cos_sum = (cs > S_MAX) ? SUM_W'(S_MAX) : (cs < S_MIN) ? SUM_W'(S_MIN)
                                                                    : SUM_W'(cs);
            n_sin_sum = (ss > S_MAX) ? SUM_W'(S_MAX) : (ss < S_MIN) ? SUM_W'(S_MIN)
                                                                    : SUM_W'(ss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_sum <= '0;
            r_sin_sum <= '0;
        end else begin
            r_cos_sum <= n_cos_sum;
            r_sin_sum <= n_sin_sum;
        end
    end

    assign o_cos_sum   = r_cos_sum;
    assign o_sin_sum   = r_sin_sum;
    assign o_sums_zero = (r_cos_sum == '0) && (r_sin_sum == '0);

endmodule

`default_nettype wire

// ===== rtl/core/cma_ctrl.sv =====
// ----------------------------------------------------------------------------
// cma_ctrl
// Sequencer for the shared CORDIC unit, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_ctrl (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire [1:0]                             i_quad,
    input  wire                                   i_last,
    input  wire                                   i_sums_zero,
    input  wire signed [cma_pkg::Z_W-1:0]         i_z,
    output cma_pkg::t_cordic_ctl                  o_cordic_ctl,
    output cma_pkg::t_acc_ctl                     o_acc_ctl,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [cma_pkg::ANGLE_W-1:0]    o_mean
);
    import cma_pkg::*;

    localparam logic signed [Z_W-1:0] Z_RND = Z_W'(32768);

    t_cma_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_out_valid, n_out_valid;
    logic [1:0] r_quad;
    logic r_last, r_zero;
    logic signed [ANGLE_W-1:0] r_mean;
    logic signed [Z_W-1:0] z_rnd;

    logic accept, stepping, out_load;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign stepping = (r_state == ST_ROT) || (r_state == ST_VEC);
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign z_rnd    = i_z + Z_RND;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_ROT;
            ST_ROT:   if (r_step == STEP_LAST) n_state = ST_ACC;
            ST_ACC:   n_state = r_last ? ST_VLOAD : ST_IDLE;
            ST_VLOAD: n_state = i_sums_zero ? ST_OUT : ST_VEC;
            ST_VEC:   if (r_step == STEP_LAST) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready          = (r_state == ST_IDLE);
        o_cordic_ctl.load   = accept || (r_state == ST_VLOAD);
        o_cordic_ctl.vector = (r_state == ST_VLOAD) || (r_state == ST_VEC);
        o_cordic_ctl.step   = stepping;
        o_cordic_ctl.idx    = r_step;
        o_acc_ctl.add       = (r_state == ST_ACC);
        o_acc_ctl.clear     = (r_state == ST_VLOAD);
        o_acc_ctl.quad      = r_quad;
    end

    always_comb begin
        n_step      = (stepping && (r_step != STEP_LAST)) ? r_step + 1'b1 : '0;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_quad <= i_quad;
            r_last <= i_last;
        end
        if (r_state == ST_VLOAD) begin
            r_zero <= i_sums_zero;
        end
        if (out_load) begin
            r_mean <= r_zero ? '0 : z_rnd[31:16];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mean      = r_mean;

endmodule

`default_nettype wire

// ===== rtl/core/circular_mean_angle.sv =====
// ----------------------------------------------------------------------------
// circular_mean_angle
// Circular mean of sets of angles through one shared CORDIC unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  angle   | in        | i_in_valid / o_in_ready   | i_angle_in, i_last_of_set
//  mean    | out       | o_out_valid / i_out_ready | o_mean_angle
//
//  An ordinary angle goes through accept, one rotation step per cycle and
//  then an accumulate step. The last angle of a set adds a load step and
//  CORDIC_STEPS vectoring steps (skipped when both sums are zero) and the
//  write of the result register, which waits while a stalled result is held.
//  There is a single CORDIC iteration stage; ready is high only while the
//  sequencer is idle.
//  Reset (synchronous, active low) clears the sums, sequencer and result valid.
//  A stalled result beat waits in the output register; the next set's
//  angles are taken meanwhile, and only the next result beat waits for it.
//
`default_nettype none

module circular_mean_angle (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire [cma_pkg::ANGLE_W-1:0]            i_angle_in,
    input  wire                                   i_last_of_set,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [cma_pkg::ANGLE_W-1:0]    o_mean_angle
);
    import cma_pkg::*;

    `include "circular_mean_angle_assert.svh"

    t_cordic_ctl cordic_ctl;
    t_acc_ctl    acc_ctl;

    logic signed [XY_W-1:0]  cx, cy;
    logic signed [Z_W-1:0]   cz;
    logic signed [SUM_W-1:0] cos_sum, sin_sum;
    logic                    sums_zero;

    // Sequencer: captures quadrant and last flag, drives the shared unit.
    cma_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_quad       (i_angle_in[ANGLE_W-1:REM_W]),
        .i_last       (i_last_of_set),
        .i_sums_zero  (sums_zero),
        .i_z          (cz),
        .o_cordic_ctl (cordic_ctl),
        .o_acc_ctl    (acc_ctl),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean       (o_mean_angle)
    );

    // Shared CORDIC: the remainder is loaded straight off the input on accept.
    cma_cordic u_cordic (
        .i_clk       (i_clk),
        .i_ctl       (cordic_ctl),
        .i_angle_rem (i_angle_in[REM_W-1:0]),
        .i_cos_sum   (cos_sum),
        .i_sin_sum   (sin_sum),
        .o_x         (cx),
        .o_y         (cy),
        .o_z         (cz)
    );

    // Running sums; cleared as the vectoring pass takes them.
    cma_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_x         (cx),
        .i_y         (cy),
        .o_cos_sum   (cos_sum),
        .o_sin_sum   (sin_sum),
        .o_sums_zero (sums_zero)
    );

    // Hold off new angles while the unit iterates.
    `CMA_ASSERT_SAME(a_ready_not_busy, i_clk, i_rst_n, o_in_ready, !cordic_ctl.step,
                     "input ready while CORDIC is stepping")
    // Drop ready straight after an accepted beat.
    `CMA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
                     !o_in_ready, "ready stayed high after an accepted beat")
    // Never load the shared unit in the same cycle as a step or an accumulate add.
    `CMA_ASSERT_SAME(a_load_step_excl, i_clk, i_rst_n, cordic_ctl.load,
                     !cordic_ctl.step && !acc_ctl.add, "CORDIC load overlaps step or add")

endmodule

`default_nettype wire
